// File: sv/jbse_pkg.sv
`timescale 1ns / 1ps
package jbse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int LOCAL_SLOTS = 256;
  localparam int SP_W        = 7;   // holds 0..STACK_DEPTH
  localparam int SA_W        = 6;   // stack entry index
  localparam int LA_W        = 8;   // local slot index

  // commands
  localparam logic [4:0] CMD_NOP       = 5'd0;
  localparam logic [4:0] CMD_PUSH      = 5'd1;
  localparam logic [4:0] CMD_PUSH_LONG = 5'd2;
  localparam logic [4:0] CMD_LOAD      = 5'd3;
  localparam logic [4:0] CMD_LOAD_LONG = 5'd4;
  localparam logic [4:0] CMD_STORE     = 5'd5;
  localparam logic [4:0] CMD_STORE_LNG = 5'd6;
  localparam logic [4:0] CMD_IADD      = 5'd7;
  localparam logic [4:0] CMD_ISUB      = 5'd8;
  localparam logic [4:0] CMD_IMUL      = 5'd9;
  localparam logic [4:0] CMD_IDIV      = 5'd10;
  localparam logic [4:0] CMD_IREM      = 5'd11;
  localparam logic [4:0] CMD_INEG      = 5'd12;
  localparam logic [4:0] CMD_IINC      = 5'd13;
  localparam logic [4:0] CMD_LADD      = 5'd14;
  localparam logic [4:0] CMD_LSUB      = 5'd15;
  localparam logic [4:0] CMD_LMUL      = 5'd16;
  localparam logic [4:0] CMD_LDIV      = 5'd17;
  localparam logic [4:0] CMD_LREM      = 5'd18;
  localparam logic [4:0] CMD_LNEG      = 5'd19;
  localparam logic [4:0] CMD_POP       = 5'd20;
  localparam logic [4:0] CMD_POP2      = 5'd21;
  localparam logic [4:0] CMD_DUP       = 5'd22;
  localparam logic [4:0] CMD_DUP_X1    = 5'd23;
  localparam logic [4:0] CMD_DUP_X2    = 5'd24;
  localparam logic [4:0] CMD_DUP2      = 5'd25;
  localparam logic [4:0] CMD_SWAP      = 5'd26;
  localparam logic [4:0] CMD_LCMP      = 5'd27;
  localparam logic [4:0] CMD_IF_ZERO   = 5'd28;
  localparam logic [4:0] CMD_IF_ICMP   = 5'd29;
  localparam logic [4:0] CMD_GOTO      = 5'd30;

  // branch conditions
  localparam logic [2:0] COND_EQ = 3'd0;
  localparam logic [2:0] COND_NE = 3'd1;
  localparam logic [2:0] COND_LT = 3'd2;
  localparam logic [2:0] COND_GE = 3'd3;
  localparam logic [2:0] COND_GT = 3'd4;
  localparam logic [2:0] COND_LE = 3'd5;

  // fault codes
  localparam logic [2:0] FLT_OK    = 3'd0;
  localparam logic [2:0] FLT_DIV0  = 3'd1;
  localparam logic [2:0] FLT_OVER  = 3'd2;
  localparam logic [2:0] FLT_UNDER = 3'd3;
  localparam logic [2:0] FLT_LOCAL = 3'd4;

  // words popped
  function automatic logic [2:0] pops(input logic [4:0] c);
    case (c)
      CMD_STORE, CMD_INEG, CMD_POP, CMD_DUP, CMD_IF_ZERO: pops = 3'd1;
      CMD_STORE_LNG, CMD_IADD, CMD_ISUB, CMD_IMUL, CMD_IDIV, CMD_IREM,
      CMD_LNEG, CMD_POP2, CMD_DUP_X1, CMD_DUP2, CMD_SWAP, CMD_IF_ICMP: pops = 3'd2;
      CMD_DUP_X2: pops = 3'd3;
      CMD_LADD, CMD_LSUB, CMD_LMUL, CMD_LDIV, CMD_LREM, CMD_LCMP: pops = 3'd4;
      default: pops = 3'd0;
    endcase
  endfunction

  // words pushed
  function automatic logic [2:0] pushes(input logic [4:0] c);
    case (c)
      CMD_PUSH, CMD_LOAD, CMD_IADD, CMD_ISUB, CMD_IMUL, CMD_IDIV, CMD_IREM,
      CMD_INEG, CMD_LCMP: pushes = 3'd1;
      CMD_PUSH_LONG, CMD_LOAD_LONG, CMD_LADD, CMD_LSUB, CMD_LMUL, CMD_LDIV,
      CMD_LREM, CMD_LNEG, CMD_DUP, CMD_SWAP: pushes = 3'd2;
      CMD_DUP_X1: pushes = 3'd3;
      CMD_DUP_X2, CMD_DUP2: pushes = 3'd4;
      default: pushes = 3'd0;
    endcase
  endfunction

  // local slots touched (range check)
  function automatic logic [1:0] loc_use(input logic [4:0] c);
    case (c)
      CMD_LOAD, CMD_STORE, CMD_IINC: loc_use = 2'd1;
      CMD_LOAD_LONG, CMD_STORE_LNG:  loc_use = 2'd2;
      default: loc_use = 2'd0;
    endcase
  endfunction

  // local slots read
  function automatic logic [1:0] loc_rd(input logic [4:0] c);
    case (c)
      CMD_LOAD, CMD_IINC: loc_rd = 2'd1;
      CMD_LOAD_LONG:      loc_rd = 2'd2;
      default: loc_rd = 2'd0;
    endcase
  endfunction

  // local slots written
  function automatic logic [1:0] loc_wr(input logic [4:0] c);
    case (c)
      CMD_STORE, CMD_IINC: loc_wr = 2'd1;
      CMD_STORE_LNG:       loc_wr = 2'd2;
      default: loc_wr = 2'd0;
    endcase
  endfunction

endpackage

// File: sv/java_bytecode_stack_execute.sv
`timescale 1ns / 1ps
// Executes one decoded stack-machine instruction per input beat.
// Input channel in_*: one instruction per beat. Output channel out_*: one
// result beat per instruction with the new program counter, branch flag,
// the two top stack words, the entry count and a fault code.
// The operand stack (64 words) and the local store (256 words) live in two
// synchronous RAMs with one read and one write port each. An instruction
// walks a sequencer: decode, a read (S_RD, S_RDW) for each popped word or
// local read, execute, a write step for each pushed or stored word plus one
// to commit the stack pointer, a read-back of the top two words (S_RB0 to
// S_RB2), then the output load (S_DONE). A fault found at decode, or a
// divide by zero at execute, skips straight to the read-back. imul/lmul run
// through S_MUL0 to S_MUL3 on a shared 32x32 multiplier, and
// idiv/irem/ldiv/lrem run through the bit-serial 64-bit divider. One
// instruction is worked on at a time; the next beat is taken while the
// previous result still waits in the output register. When the receiver
// stalls, a finished result holds in the sequencer until the output
// register frees up. Reset clears the sequencer state, stack pointer,
// program counter and output valid; RAM contents are undefined until written.
module java_bytecode_stack_execute (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[4:0], local_index[12:5], small_constant[20:13],
  // immediate[36:21], condition[39:37], instr_length[41:40]
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // next_pc[15:0], branch_taken[16], top_word[48:17], second_word[80:49],
  // stack_count[87:81], fault[90:88]
  output logic [95:0] out_tdata
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_RDW  = 4'd3;
  localparam logic [3:0] S_EXEC = 4'd4;
  localparam logic [3:0] S_MUL0 = 4'd5;
  localparam logic [3:0] S_MUL1 = 4'd6;
  localparam logic [3:0] S_MUL2 = 4'd7;
  localparam logic [3:0] S_MUL3 = 4'd8;
  localparam logic [3:0] S_DIV0 = 4'd9;
  localparam logic [3:0] S_DIV1 = 4'd10;
  localparam logic [3:0] S_WR   = 4'd11;
  localparam logic [3:0] S_RB0  = 4'd12;
  localparam logic [3:0] S_RB1  = 4'd13;
  localparam logic [3:0] S_RB2  = 4'd14;
  localparam logic [3:0] S_DONE = 4'd15;

  logic [3:0] state_r, state_nxt;

  // captured instruction
  logic [4:0]  cmd_r, cmd_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  k_r, k_nxt;
  logic [15:0] imm_r, imm_nxt;
  logic [2:0]  cond_r, cond_nxt;
  logic [1:0]  len_r, len_nxt;

  // architectural state
  logic [jbse_pkg::SP_W-1:0] sp_r, sp_nxt;
  logic [15:0] pc_r, pc_nxt;

  // working registers
  logic [15:0] npc_r, npc_nxt;
  logic        taken_r, taken_nxt;
  logic [2:0]  fault_r, fault_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [31:0] v_r [4];
  logic [31:0] v_nxt [4];
  logic [31:0] l_r [2];
  logic [31:0] l_nxt [2];
  logic [31:0] r_r [4];
  logic [31:0] r_nxt [4];
  logic [31:0] lw_r [2];
  logic [31:0] lw_nxt [2];
  logic [31:0] top_r, top_nxt, sec_r, sec_nxt;
  logic [63:0] mp_r, mp_nxt;
  logic [31:0] mhi_r, mhi_nxt, mlo_r, mlo_nxt;
  logic        negq_r, negq_nxt, negr_r, negr_nxt;
  logic [63:0] ma_r, ma_nxt, mb_r, mb_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [95:0] out_data_r, out_data_nxt;

  // memories
  logic [31:0] stk_mem [jbse_pkg::STACK_DEPTH];
  logic [31:0] loc_mem [jbse_pkg::LOCAL_SLOTS];
  logic [31:0] s_rd_r, l_rd_r;
  logic        s_we, l_we;
  logic [jbse_pkg::SA_W-1:0] s_ra, s_wa;
  logic [jbse_pkg::LA_W-1:0] l_ra, l_wa;
  logic [31:0] s_wd, l_wd;

  // divider
  logic        div_start, div_busy;
  logic [63:0] div_q, div_r;

  // decode helpers
  logic [2:0]  np, nq;
  logic [1:0]  nlu, nlr, nlw;
  logic [2:0]  nrd, nwr;
  logic        is_long;
  logic [63:0] a64, b64, t64;
  logic [31:0] imm32, k32;
  logic [jbse_pkg::SP_W-1:0] sp_base, tmp_a;
  logic [7:0]  sp_after;
  logic [8:0]  idx_hi;
  logic [2:0]  lofs;
  logic [31:0] mx, my;
  logic [63:0] qs, rs;

  jbse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ma_r),
    .divisor  (mb_r),
    .busy     (div_busy),
    .quot     (div_q),
    .remd     (div_r)
  );

  function automatic logic cond_ok(input logic [31:0] a, input logic [31:0] b,
                                   input logic [2:0] c);
    case (c)
      jbse_pkg::COND_EQ: cond_ok = (a == b);
      jbse_pkg::COND_NE: cond_ok = (a != b);
      jbse_pkg::COND_LT: cond_ok = ($signed(a) <  $signed(b));
      jbse_pkg::COND_GE: cond_ok = ($signed(a) >= $signed(b));
      jbse_pkg::COND_GT: cond_ok = ($signed(a) >  $signed(b));
      jbse_pkg::COND_LE: cond_ok = ($signed(a) <= $signed(b));
      default: cond_ok = 1'b0;
    endcase
  endfunction

  // per-command counts
  always_comb begin
    np      = jbse_pkg::pops(cmd_r);
    nq      = jbse_pkg::pushes(cmd_r);
    nlu     = jbse_pkg::loc_use(cmd_r);
    nlr     = jbse_pkg::loc_rd(cmd_r);
    nlw     = jbse_pkg::loc_wr(cmd_r);
    nrd     = np + {1'b0, nlr};
    nwr     = (nq > {1'b0, nlw}) ? nq : {1'b0, nlw};
    is_long = (cmd_r >= jbse_pkg::CMD_LADD) && (cmd_r <= jbse_pkg::CMD_LREM);
    a64     = is_long ? {v_r[3], v_r[2]} : {32'd0, v_r[1]};
    b64     = is_long ? {v_r[1], v_r[0]} : {32'd0, v_r[0]};
    imm32   = {{16{imm_r[15]}}, imm_r};
    k32     = {{24{k_r[7]}}, k_r};
    sp_base = sp_r - {{(jbse_pkg::SP_W-3){1'b0}}, np};
    sp_after = {1'b0, sp_base} + {5'd0, nq};
    idx_hi  = {1'b0, idx_r} + 9'd1;
    lofs    = cnt_r - np;
  end

  // memory address and write control
  always_comb begin
    s_we  = 1'b0;
    l_we  = 1'b0;
    tmp_a = sp_r - 7'd1 - {4'd0, cnt_r};
    s_wa  = '0;
    s_wd  = r_r[cnt_r[1:0]];
    l_wa  = idx_r + {6'd0, cnt_r[1:0]};
    l_wd  = lw_r[cnt_r[0]];
    l_ra  = idx_r + {6'd0, lofs[1:0]};
    case (state_r)
      S_RB0: begin
        tmp_a = sp_r - 7'd1;
      end
      S_RB1: begin
        tmp_a = sp_r - 7'd2;
      end
      S_WR: begin
        s_wa = jbse_pkg::SA_W'(sp_base + {4'd0, cnt_r});
        s_we = (cnt_r < nq);
        l_we = ({1'b0, cnt_r} < {2'b0, nlw});
      end
      default: begin
      end
    endcase
    s_ra = tmp_a[jbse_pkg::SA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      stk_mem[s_wa] <= s_wd;
    end
    s_rd_r <= stk_mem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      loc_mem[l_wa] <= l_wd;
    end
    l_rd_r <= loc_mem[l_ra];
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    idx_nxt    = idx_r;
    k_nxt      = k_r;
    imm_nxt    = imm_r;
    cond_nxt   = cond_r;
    len_nxt    = len_r;
    sp_nxt     = sp_r;
    pc_nxt     = pc_r;
    npc_nxt    = npc_r;
    taken_nxt  = taken_r;
    fault_nxt  = fault_r;
    cnt_nxt    = cnt_r;
    v_nxt      = v_r;
    l_nxt      = l_r;
    r_nxt      = r_r;
    lw_nxt     = lw_r;
    top_nxt    = top_r;
    sec_nxt    = sec_r;
    mhi_nxt    = mhi_r;
    mlo_nxt    = mlo_r;
    negq_nxt   = negq_r;
    negr_nxt   = negr_r;
    ma_nxt     = ma_r;
    mb_nxt     = mb_r;
    div_start  = 1'b0;
    t64        = 64'd0;
    qs         = 64'd0;
    rs         = 64'd0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_tready  = (state_r == S_IDLE);

    // shared multiplier operand select
    mx = a64[31:0];
    my = b64[31:0];
    if (state_r == S_MUL1) begin
      mx = a64[63:32];
    end else if (state_r == S_MUL2) begin
      my = b64[63:32];
    end
    mp_nxt = {32'd0, mx} * {32'd0, my};

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tdata[4:0];
          idx_nxt   = in_tdata[12:5];
          k_nxt     = in_tdata[20:13];
          imm_nxt   = in_tdata[36:21];
          cond_nxt  = in_tdata[39:37];
          len_nxt   = in_tdata[41:40];
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        npc_nxt   = pc_r + {14'd0, len_r};
        taken_nxt = 1'b0;
        fault_nxt = jbse_pkg::FLT_OK;
        cnt_nxt   = 3'd0;
        if (sp_r < {4'd0, np}) begin
          fault_nxt = jbse_pkg::FLT_UNDER;
          state_nxt = S_RB0;
        end else if (nlu != 2'd0 &&
                     ({1'b0, idx_r} >= 9'(jbse_pkg::LOCAL_SLOTS) ||
                      (nlu == 2'd2 && idx_hi >= 9'(jbse_pkg::LOCAL_SLOTS)))) begin
          fault_nxt = jbse_pkg::FLT_LOCAL;
          state_nxt = S_RB0;
        end else if (sp_after > 8'(jbse_pkg::STACK_DEPTH)) begin
          fault_nxt = jbse_pkg::FLT_OVER;
          state_nxt = S_RB0;
        end else if (nrd != 3'd0) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_RD: begin
        state_nxt = S_RDW;
      end
      S_RDW: begin
        if (cnt_r < np) begin
          v_nxt[cnt_r[1:0]] = s_rd_r;
        end else begin
          l_nxt[lofs[0]] = l_rd_r;
        end
        if (cnt_r + 3'd1 == nrd) begin
          cnt_nxt   = 3'd0;
          state_nxt = S_EXEC;
        end else begin
          cnt_nxt   = cnt_r + 3'd1;
          state_nxt = S_RD;
        end
      end
      S_EXEC: begin
        state_nxt = S_WR;
        cnt_nxt   = 3'd0;
        case (cmd_r)
          jbse_pkg::CMD_PUSH:      r_nxt[0] = imm32;
          jbse_pkg::CMD_PUSH_LONG: begin
            r_nxt[0] = {32{imm32[31]}};
            r_nxt[1] = imm32;
          end
          jbse_pkg::CMD_LOAD:      r_nxt[0] = l_r[0];
          jbse_pkg::CMD_LOAD_LONG: begin
            r_nxt[0] = l_r[0];
            r_nxt[1] = l_r[1];
          end
          jbse_pkg::CMD_STORE:     lw_nxt[0] = v_r[0];
          jbse_pkg::CMD_STORE_LNG: begin
            lw_nxt[0] = v_r[1];
            lw_nxt[1] = v_r[0];
          end
          jbse_pkg::CMD_IADD: r_nxt[0] = v_r[1] + v_r[0];
          jbse_pkg::CMD_ISUB: r_nxt[0] = v_r[1] - v_r[0];
          jbse_pkg::CMD_INEG: r_nxt[0] = 32'd0 - v_r[0];
          jbse_pkg::CMD_IINC: lw_nxt[0] = l_r[0] + k32;
          jbse_pkg::CMD_LADD, jbse_pkg::CMD_LSUB, jbse_pkg::CMD_LNEG: begin
            if (cmd_r == jbse_pkg::CMD_LADD) begin
              t64 = a64 + b64;
            end else if (cmd_r == jbse_pkg::CMD_LSUB) begin
              t64 = a64 - b64;
            end else begin
              t64 = 64'd0 - {v_r[1], v_r[0]};
            end
            r_nxt[0] = t64[63:32];
            r_nxt[1] = t64[31:0];
          end
          jbse_pkg::CMD_IMUL, jbse_pkg::CMD_LMUL: state_nxt = S_MUL0;
          jbse_pkg::CMD_IDIV, jbse_pkg::CMD_IREM,
          jbse_pkg::CMD_LDIV, jbse_pkg::CMD_LREM: begin
            if (b64 == 64'd0) begin
              fault_nxt = jbse_pkg::FLT_DIV0;
              state_nxt = S_RB0;
            end else begin
              if (is_long) begin
                negr_nxt = a64[63];
                negq_nxt = a64[63] ^ b64[63];
                ma_nxt   = a64[63] ? 64'd0 - a64 : a64;
                mb_nxt   = b64[63] ? 64'd0 - b64 : b64;
              end else begin
                negr_nxt = v_r[1][31];
                negq_nxt = v_r[1][31] ^ v_r[0][31];
                ma_nxt   = {32'd0, v_r[1][31] ? 32'd0 - v_r[1] : v_r[1]};
                mb_nxt   = {32'd0, v_r[0][31] ? 32'd0 - v_r[0] : v_r[0]};
              end
              state_nxt = S_DIV0;
            end
          end
          jbse_pkg::CMD_DUP: begin
            r_nxt[0] = v_r[0];
            r_nxt[1] = v_r[0];
          end
          jbse_pkg::CMD_DUP_X1: begin
            r_nxt[0] = v_r[0];
            r_nxt[1] = v_r[1];
            r_nxt[2] = v_r[0];
          end
          jbse_pkg::CMD_DUP_X2: begin
            r_nxt[0] = v_r[0];
            r_nxt[1] = v_r[2];
            r_nxt[2] = v_r[1];
            r_nxt[3] = v_r[0];
          end
          jbse_pkg::CMD_DUP2: begin
            r_nxt[0] = v_r[1];
            r_nxt[1] = v_r[0];
            r_nxt[2] = v_r[1];
            r_nxt[3] = v_r[0];
          end
          jbse_pkg::CMD_SWAP: begin
            r_nxt[0] = v_r[0];
            r_nxt[1] = v_r[1];
          end
          // long compare: deeper pair against the top pair
          jbse_pkg::CMD_LCMP: begin
            if ($signed({v_r[3], v_r[2]}) > $signed({v_r[1], v_r[0]})) begin
              r_nxt[0] = 32'd1;
            end else if ($signed({v_r[3], v_r[2]}) < $signed({v_r[1], v_r[0]})) begin
              r_nxt[0] = 32'hFFFF_FFFF;
            end else begin
              r_nxt[0] = 32'd0;
            end
          end
          jbse_pkg::CMD_IF_ZERO: taken_nxt = cond_ok(v_r[0], 32'd0, cond_r);
          jbse_pkg::CMD_IF_ICMP: taken_nxt = cond_ok(v_r[1], v_r[0], cond_r);
          jbse_pkg::CMD_GOTO:    taken_nxt = 1'b1;
          default: begin
          end
        endcase
      end
      // 64-bit low product from three 32x32 partial products
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: begin
        mlo_nxt   = mp_r[31:0];
        mhi_nxt   = mp_r[63:32];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        mhi_nxt   = mhi_r + mp_r[31:0];
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        t64 = {mhi_r + mp_r[31:0], mlo_r};
        if (is_long) begin
          r_nxt[0] = t64[63:32];
          r_nxt[1] = t64[31:0];
        end else begin
          r_nxt[0] = t64[31:0];
        end
        state_nxt = S_WR;
      end
      S_DIV0: begin
        div_start = 1'b1;
        state_nxt = S_DIV1;
      end
      S_DIV1: begin
        if (!div_busy) begin
          qs = negq_r ? 64'd0 - div_q : div_q;
          rs = negr_r ? 64'd0 - div_r : div_r;
          t64 = (cmd_r == jbse_pkg::CMD_IREM || cmd_r == jbse_pkg::CMD_LREM) ? rs : qs;
          if (is_long) begin
            r_nxt[0] = t64[63:32];
            r_nxt[1] = t64[31:0];
          end else begin
            r_nxt[0] = t64[31:0];
          end
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        if (cnt_r < nwr) begin
          cnt_nxt = cnt_r + 3'd1;
        end else begin
          sp_nxt = sp_after[jbse_pkg::SP_W-1:0];
          if (taken_r) begin
            npc_nxt = pc_r + imm_r;
          end
          state_nxt = S_RB0;
        end
      end
      S_RB0: state_nxt = S_RB1;
      S_RB1: begin
        top_nxt   = (sp_r >= 7'd1) ? s_rd_r : 32'd0;
        state_nxt = S_RB2;
      end
      S_RB2: begin
        sec_nxt   = (sp_r >= 7'd2) ? s_rd_r : 32'd0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0, fault_r, sp_r, sec_r, top_r, taken_r, npc_r};
          pc_nxt        = npc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      pc_r        <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    k_r        <= k_nxt;
    imm_r      <= imm_nxt;
    cond_r     <= cond_nxt;
    len_r      <= len_nxt;
    npc_r      <= npc_nxt;
    taken_r    <= taken_nxt;
    fault_r    <= fault_nxt;
    cnt_r      <= cnt_nxt;
    v_r        <= v_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    lw_r       <= lw_nxt;
    top_r      <= top_nxt;
    sec_r      <= sec_nxt;
    mp_r       <= mp_nxt;
    mhi_r      <= mhi_nxt;
    mlo_r      <= mlo_nxt;
    negq_r     <= negq_nxt;
    negr_r     <= negr_nxt;
    ma_r       <= ma_nxt;
    mb_r       <= mb_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: sv/jbse_div.sv
`timescale 1ns / 1ps
// Unsigned 64-bit restoring divider, one quotient bit per cycle.
module jbse_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quot,
  output logic [63:0] remd
);

  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] q_r, q_nxt, rm_r, rm_nxt, d_r, d_nxt;
  logic [64:0] trial;
  logic        ge;

  // one shift-subtract step
  always_comb begin
    trial    = {rm_r, q_r[63]};
    ge       = (trial >= {1'b0, d_r});
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    q_nxt    = q_r;
    rm_nxt   = rm_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 7'd0;
      q_nxt    = dividend;
      rm_nxt   = 64'd0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      if (ge) begin
        trial = trial - {1'b0, d_r};
      end
      rm_nxt  = trial[63:0];
      q_nxt   = {q_r[62:0], ge};
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r  <= q_nxt;
    rm_r <= rm_nxt;
    d_r  <= d_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;
  assign remd = rm_r;

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int HOLD_LEN = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;

  // packed from the top bit down: fault lands in the highest bits
  typedef struct packed {
    logic [2:0]  fault;
    logic [6:0]  stack_count;
    logic [31:0] second_word;
    logic [31:0] top_word;
    logic        branch_taken;
    logic [15:0] next_pc;
  } exec_result_t;

  // shadow machine state
  logic [31:0] shadow_stack [jbse_pkg::STACK_DEPTH];
  int          shadow_sp;
  logic [31:0] shadow_locals [jbse_pkg::LOCAL_SLOTS];
  bit          local_written [jbse_pkg::LOCAL_SLOTS];
  logic [15:0] shadow_pc;

  exec_result_t pending_results[$];
  int  mismatches;
  int  quiet_cycles;
  int  src_idle_pct;
  int  snk_stall_pct;
  int  hold_cycles;
  int  hold_req;
  int  hold_seen;

  java_bytecode_stack_execute u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #6 clk = ~clk;

  // stack words consumed by each command
  function automatic int words_popped(input logic [4:0] c);
    case (c)
      jbse_pkg::CMD_STORE, jbse_pkg::CMD_INEG, jbse_pkg::CMD_POP, jbse_pkg::CMD_DUP,
      jbse_pkg::CMD_IF_ZERO: return 1;
      jbse_pkg::CMD_STORE_LNG, jbse_pkg::CMD_IADD, jbse_pkg::CMD_ISUB,
      jbse_pkg::CMD_IMUL, jbse_pkg::CMD_IDIV, jbse_pkg::CMD_IREM, jbse_pkg::CMD_LNEG,
      jbse_pkg::CMD_POP2, jbse_pkg::CMD_DUP_X1, jbse_pkg::CMD_DUP2, jbse_pkg::CMD_SWAP,
      jbse_pkg::CMD_IF_ICMP: return 2;
      jbse_pkg::CMD_DUP_X2: return 3;
      jbse_pkg::CMD_LADD, jbse_pkg::CMD_LSUB, jbse_pkg::CMD_LMUL, jbse_pkg::CMD_LDIV,
      jbse_pkg::CMD_LREM, jbse_pkg::CMD_LCMP: return 4;
      default: return 0;
    endcase
  endfunction

  function automatic int words_pushed(input logic [4:0] c);
    case (c)
      jbse_pkg::CMD_PUSH, jbse_pkg::CMD_LOAD, jbse_pkg::CMD_IADD, jbse_pkg::CMD_ISUB,
      jbse_pkg::CMD_IMUL, jbse_pkg::CMD_IDIV, jbse_pkg::CMD_IREM, jbse_pkg::CMD_INEG,
      jbse_pkg::CMD_LCMP: return 1;
      jbse_pkg::CMD_PUSH_LONG, jbse_pkg::CMD_LOAD_LONG, jbse_pkg::CMD_LADD,
      jbse_pkg::CMD_LSUB, jbse_pkg::CMD_LMUL, jbse_pkg::CMD_LDIV, jbse_pkg::CMD_LREM,
      jbse_pkg::CMD_LNEG, jbse_pkg::CMD_DUP, jbse_pkg::CMD_SWAP: return 2;
      jbse_pkg::CMD_DUP_X1: return 3;
      jbse_pkg::CMD_DUP_X2, jbse_pkg::CMD_DUP2: return 4;
      default: return 0;
    endcase
  endfunction

  function automatic bit cond_holds(input logic [31:0] a, input logic [31:0] b,
                                    input logic [2:0] cc);
    case (cc)
      jbse_pkg::COND_EQ: return $signed(a) == $signed(b);
      jbse_pkg::COND_NE: return $signed(a) != $signed(b);
      jbse_pkg::COND_LT: return $signed(a) <  $signed(b);
      jbse_pkg::COND_GE: return $signed(a) >= $signed(b);
      jbse_pkg::COND_GT: return $signed(a) >  $signed(b);
      jbse_pkg::COND_LE: return $signed(a) <= $signed(b);
      default: return 1'b0;
    endcase
  endfunction

  // Java-style signed divide: truncate toward zero, MIN / -1 wraps to MIN
  function automatic logic [63:0] java_div64(input logic [63:0] a, input logic [63:0] b,
                                             input bit rem, input int bits);
    logic [63:0] min_v;
    logic [63:0] q;
    min_v = 64'd1 << (bits - 1);
    if (bits == 32) begin
      if (a[31:0] == min_v[31:0] && b[31:0] == 32'hFFFF_FFFF) return rem ? 64'd0 : min_v;
      q = rem ? 64'($signed(a[31:0]) % $signed(b[31:0]))
              : 64'($signed(a[31:0]) / $signed(b[31:0]));
    end else begin
      if (a == min_v && b == '1) return rem ? 64'd0 : min_v;
      q = rem ? $signed(a) % $signed(b) : $signed(a) / $signed(b);
    end
    return q;
  endfunction

  // execute one instruction on the shadow machine and queue its result
  task automatic execute_shadow(input logic [47:0] beat);
    logic [4:0]  cmd;
    logic [7:0]  idx;
    logic [31:0] imm32, k32;
    logic [2:0]  cc;
    logic [31:0] v [4];
    logic [31:0] r [4];
    logic [63:0] a64, b64, t64;
    logic [15:0] nxt;
    logic [2:0]  flt;
    bit          taken;
    int          np, nq, luse;
    exec_result_t res;
    cmd   = beat[4:0];
    idx   = beat[12:5];
    k32   = {{24{beat[20]}}, beat[20:13]};
    imm32 = {{16{beat[36]}}, beat[36:21]};
    cc    = beat[39:37];
    nxt   = shadow_pc + 16'(beat[41:40]);
    np    = words_popped(cmd);
    nq    = words_pushed(cmd);
    luse  = (cmd == jbse_pkg::CMD_LOAD || cmd == jbse_pkg::CMD_STORE ||
             cmd == jbse_pkg::CMD_IINC) ? 1 :
            (cmd == jbse_pkg::CMD_LOAD_LONG || cmd == jbse_pkg::CMD_STORE_LNG) ? 2 : 0;
    taken = 1'b0;
    flt   = jbse_pkg::FLT_OK;
    for (int i = 0; i < 4; i++) begin
      v[i] = '0;
      r[i] = '0;
    end
    if (shadow_sp < np) flt = jbse_pkg::FLT_UNDER;
    else if (luse == 2 && idx == 8'd255) flt = jbse_pkg::FLT_LOCAL;
    else if (shadow_sp - np + nq > jbse_pkg::STACK_DEPTH) flt = jbse_pkg::FLT_OVER;
    else begin
      for (int i = 0; i < np; i++) v[i] = shadow_stack[shadow_sp - 1 - i];
      if ((cmd == jbse_pkg::CMD_IDIV || cmd == jbse_pkg::CMD_IREM) && v[0] == 0)
        flt = jbse_pkg::FLT_DIV0;
      if ((cmd == jbse_pkg::CMD_LDIV || cmd == jbse_pkg::CMD_LREM) && v[0] == 0 && v[1] == 0)
        flt = jbse_pkg::FLT_DIV0;
    end
    if (flt == jbse_pkg::FLT_OK) begin
      b64 = {v[1], v[0]};
      a64 = {v[3], v[2]};
      t64 = '0;
      case (cmd)
        jbse_pkg::CMD_PUSH:      r[0] = imm32;
        jbse_pkg::CMD_PUSH_LONG: begin r[0] = {32{imm32[31]}}; r[1] = imm32; end
        jbse_pkg::CMD_LOAD:      r[0] = shadow_locals[idx];
        jbse_pkg::CMD_LOAD_LONG: begin
          r[0] = shadow_locals[idx];
          r[1] = shadow_locals[idx + 1];
        end
        jbse_pkg::CMD_STORE: begin
          shadow_locals[idx] = v[0];
          local_written[idx] = 1'b1;
        end
        jbse_pkg::CMD_STORE_LNG: begin
          shadow_locals[idx] = v[1];
          shadow_locals[idx + 1] = v[0];
          local_written[idx] = 1'b1;
          local_written[idx + 1] = 1'b1;
        end
        jbse_pkg::CMD_IADD: r[0] = v[1] + v[0];
        jbse_pkg::CMD_ISUB: r[0] = v[1] - v[0];
        jbse_pkg::CMD_IMUL: r[0] = v[1] * v[0];
        jbse_pkg::CMD_IDIV: r[0] = 32'(java_div64({32'd0, v[1]}, {32'd0, v[0]}, 1'b0, 32));
        jbse_pkg::CMD_IREM: r[0] = 32'(java_div64({32'd0, v[1]}, {32'd0, v[0]}, 1'b1, 32));
        jbse_pkg::CMD_INEG: r[0] = -v[0];
        jbse_pkg::CMD_IINC: shadow_locals[idx] = shadow_locals[idx] + k32;
        jbse_pkg::CMD_LADD: t64 = a64 + b64;
        jbse_pkg::CMD_LSUB: t64 = a64 - b64;
        jbse_pkg::CMD_LMUL: t64 = a64 * b64;
        jbse_pkg::CMD_LDIV: t64 = java_div64(a64, b64, 1'b0, 64);
        jbse_pkg::CMD_LREM: t64 = java_div64(a64, b64, 1'b1, 64);
        jbse_pkg::CMD_LNEG: t64 = -b64;
        jbse_pkg::CMD_DUP:    begin r[0] = v[0]; r[1] = v[0]; end
        jbse_pkg::CMD_DUP_X1: begin r[0] = v[0]; r[1] = v[1]; r[2] = v[0]; end
        jbse_pkg::CMD_DUP_X2: begin r[0] = v[0]; r[1] = v[2]; r[2] = v[1]; r[3] = v[0]; end
        jbse_pkg::CMD_DUP2:   begin r[0] = v[1]; r[1] = v[0]; r[2] = v[1]; r[3] = v[0]; end
        jbse_pkg::CMD_SWAP:   begin r[0] = v[0]; r[1] = v[1]; end
        jbse_pkg::CMD_LCMP: r[0] = ($signed(a64) > $signed(b64)) ? 32'd1 :
                                   ($signed(a64) < $signed(b64)) ? 32'hFFFF_FFFF : 32'd0;
        jbse_pkg::CMD_IF_ZERO: taken = cond_holds(v[0], 32'd0, cc);
        jbse_pkg::CMD_IF_ICMP: taken = cond_holds(v[1], v[0], cc);
        jbse_pkg::CMD_GOTO:    taken = 1'b1;
        default: ;
      endcase
      if (cmd >= jbse_pkg::CMD_LADD && cmd <= jbse_pkg::CMD_LNEG) begin
        r[0] = t64[63:32];
        r[1] = t64[31:0];
      end
      shadow_sp -= np;
      for (int i = 0; i < nq; i++) begin
        shadow_stack[shadow_sp] = r[i];
        shadow_sp++;
      end
      if (taken) nxt = shadow_pc + imm32[15:0];
    end
    shadow_pc = nxt;
    res.next_pc      = nxt;
    res.branch_taken = taken;
    res.top_word     = shadow_sp >= 1 ? shadow_stack[shadow_sp - 1] : 32'd0;
    res.second_word  = shadow_sp >= 2 ? shadow_stack[shadow_sp - 2] : 32'd0;
    res.stack_count  = 7'(shadow_sp);
    res.fault        = flt;
    pending_results.push_back(res);
  endtask

  // offer one instruction beat and wait until it is taken
  task automatic send_instr(input logic [4:0] cmd, input logic [7:0] idx,
                            input logic [7:0] k8, input logic [15:0] imm,
                            input logic [2:0] cc, input logic [1:0] len);
    logic [47:0] beat;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    beat = {6'd0, len, cc, imm, k8, idx, cmd};
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    do @(posedge clk); while (!in_tready);
    execute_shadow(beat);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  // result checker
  always @(posedge clk) begin
    exec_result_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[90:0];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat", 32'(got.next_pc), 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.next_pc != want.next_pc)
            report_mismatch("next_pc", 32'(got.next_pc), 32'(want.next_pc));
          if (got.branch_taken != want.branch_taken)
            report_mismatch("branch_taken", 32'(got.branch_taken),
                            32'(want.branch_taken));
          if (got.top_word != want.top_word)
            report_mismatch("top_word", got.top_word, want.top_word);
          if (got.second_word != want.second_word)
            report_mismatch("second_word", got.second_word, want.second_word);
          if (got.stack_count != want.stack_count)
            report_mismatch("stack_count", 32'(got.stack_count), 32'(want.stack_count));
          if (got.fault != want.fault)
            report_mismatch("fault", 32'(got.fault), 32'(want.fault));
        end
      end
    end
  end

  // receiver: random stalls, and a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_req != hold_seen) begin
        hold_seen   <= hold_req;
        hold_cycles <= HOLD_LEN;
        out_tready  <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_tready  <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_corner_cases();
    send_instr(jbse_pkg::CMD_NOP, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd0);   // zero length
    send_instr(5'd31, 8'hFF, 8'hFF, 16'hFFFF, 3'd7, 2'd3);                    // unused command
    send_instr(jbse_pkg::CMD_POP, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd1);   // underflow
    send_instr(jbse_pkg::CMD_PUSH, 8'd0, 8'd0, 16'h8000, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_PUSH, 8'd0, 8'd0, 16'h8000, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_IMUL, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd1);
    send_instr(jbse_pkg::CMD_PUSH, 8'd0, 8'd0, 16'd2, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_IMUL, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd1);  // int MIN
    send_instr(jbse_pkg::CMD_DUP, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd1);
    send_instr(jbse_pkg::CMD_STORE, 8'd255, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_IINC, 8'd255, 8'h80, 16'd0, jbse_pkg::COND_EQ, 2'd3);
    send_instr(jbse_pkg::CMD_LOAD, 8'd255, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_POP, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd1);
    // MIN / -1 and MIN % -1
    send_instr(jbse_pkg::CMD_DUP, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd1);
    send_instr(jbse_pkg::CMD_PUSH, 8'd0, 8'd0, 16'hFFFF, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_IDIV, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd1);
    send_instr(jbse_pkg::CMD_PUSH, 8'd0, 8'd0, 16'hFFFF, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_IREM, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd1);
    // long local at the last slot, then long MIN built from a store/load pair
    send_instr(jbse_pkg::CMD_STORE_LNG, 8'd255, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_STORE_LNG, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_LOAD_LONG, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_LOAD_LONG, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_PUSH_LONG, 8'd0, 8'd0, 16'hFFFF, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_LDIV, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd1);
    send_instr(jbse_pkg::CMD_PUSH_LONG, 8'd0, 8'd0, 16'hFFFF, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_LREM, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd1);
    // divide by zero, int and long
    send_instr(jbse_pkg::CMD_PUSH_LONG, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd2);
    send_instr(jbse_pkg::CMD_LDIV, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd1);
    send_instr(jbse_pkg::CMD_IDIV, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd1);
    // branches: undefined condition, taken compare, goto backwards
    send_instr(jbse_pkg::CMD_IF_ICMP, 8'd0, 8'd0, 16'd40, 3'd6, 2'd3);
    send_instr(jbse_pkg::CMD_IF_ZERO, 8'd0, 8'd0, 16'h7FFF, jbse_pkg::COND_EQ, 2'd3);
    send_instr(jbse_pkg::CMD_GOTO, 8'd0, 8'd0, 16'h8000, jbse_pkg::COND_EQ, 2'd3);
  endtask

  // pick a command that keeps the stack in a useful range
  task automatic test_random_program(input int count);
    logic [4:0] cmd;
    logic [7:0] idx;
    for (int n = 0; n < count; n++) begin
      cmd = 5'($urandom_range(31));
      if (shadow_sp < 4 && $urandom_range(1))
        cmd = $urandom_range(1) ? jbse_pkg::CMD_PUSH : jbse_pkg::CMD_PUSH_LONG;
      if (shadow_sp > 56 && $urandom_range(1)) cmd = jbse_pkg::CMD_POP2;
      idx = $urandom_range(3) != 0 ? 8'($urandom_range(15)) : 8'($urandom_range(255));
      // never read a local that was never written
      if ((cmd == jbse_pkg::CMD_LOAD || cmd == jbse_pkg::CMD_IINC) && !local_written[idx])
        cmd = jbse_pkg::CMD_STORE;
      if (cmd == jbse_pkg::CMD_LOAD_LONG &&
          !(local_written[idx] && (idx == 8'd255 || local_written[idx + 1])))
        cmd = jbse_pkg::CMD_STORE_LNG;
      send_instr(cmd, idx, 8'($urandom), 16'($urandom), 3'($urandom_range(7)),
                 2'($urandom_range(3)));
    end
  endtask

  // receiver holds off at the start of a push run into overflow, then drain it
  task automatic test_backpressure();
    hold_req++;
    for (int n = 0; n < jbse_pkg::STACK_DEPTH + 4; n++)
      send_instr(jbse_pkg::CMD_PUSH, 8'd0, 8'd0, 16'($urandom), jbse_pkg::COND_EQ, 2'd1);
    for (int n = 0; n < jbse_pkg::STACK_DEPTH / 2; n++)
      send_instr(jbse_pkg::CMD_POP2, 8'd0, 8'd0, 16'd0, jbse_pkg::COND_EQ, 2'd1);
  endtask

  initial begin
    src_idle_pct = 0;
    snk_stall_pct = 0;
    shadow_sp = 0;
    shadow_pc = '0;
    for (int i = 0; i < jbse_pkg::LOCAL_SLOTS; i++) begin
      shadow_locals[i] = '0;
      local_written[i] = 1'b0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_random_program(170);
    src_idle_pct = 77;
    test_random_program(170);
    src_idle_pct = 0;
    snk_stall_pct = 77;
    test_random_program(170);
    src_idle_pct = 34;
    snk_stall_pct = 34;
    test_random_program(170);
    src_idle_pct = 0;
    snk_stall_pct = 0;
    test_backpressure();

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
